// ===== rtl/clock_offset_outlier_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Clock offset outlier filter assertion macros
// Shared macros for the concurrent assertions of the filter checker.
// ----------------------------------------------------------------------------
`ifndef CLOCK_OFFSET_OUTLIER_FILTER_CORE_ASSERT_SVH
`define CLOCK_OFFSET_OUTLIER_FILTER_CORE_ASSERT_SVH

// Assertion that is checked only while reset is released.
`define COOF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is held.
`define COOF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/coof_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock offset outlier filter package
// Widths, register indexes, reset values, controller states and the command
// and status bundles shared by the filter modules.
// ----------------------------------------------------------------------------
package coof_pkg;

    localparam int DATA_W     = 64;
    localparam int DEV_W      = 63;
    localparam int FACT_W     = 4;
    localparam int PROD_W     = DEV_W + FACT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 128;
    localparam int DIV_STEP   = 4;

    localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_REJECT_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT  = 2'd2;

    localparam logic [FACT_W-1:0] RST_REJECT_FACTOR = 4'd4;
    localparam logic [FACT_W-1:0] RST_ACCEPT_FACTOR = 4'd2;
    localparam logic [FACT_W-1:0] RST_WARMUP_COUNT  = 4'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEV,
        S_CHECK,
        S_DEV_PUSH,
        S_DEV_DIV_GO,
        S_DEV_DIV_WAIT,
        S_ACC_MUL,
        S_ACC_CHK,
        S_OFS_PUSH,
        S_OFS_DIV_GO,
        S_OFS_DIV_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_sample;
        logic calc_dev;
        logic mul_rej;
        logic mul_acc;
        logic dev_push;
        logic ofs_push;
        logic div_start;
        logic div_sel_ofs;
        logic wr_avg_dev;
        logic wr_avg_ofs;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic ofs_zero;
        logic early_reject;
        logic accept_ok;
        logic div_done;
    } t_dp_sts;

endpackage

// ===== rtl/coof_div.sv =====
// ----------------------------------------------------------------------------
// Clock offset outlier filter divider
// Restoring unsigned divider by a narrow count, several quotient bits per
// cycle. Signals completion with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module coof_div #(
    parameter int DIV_W = 68,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic [DIV_W-1:0] o_quotient,
    output logic             o_done
);

    localparam int ITER  = DIV_W / coof_pkg::DIV_STEP;
    localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DIV_W-1:0] n_quo;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        logic [DIV_W-1:0] q;
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] r;
        q = r_quo;
        r = r_rem;
        for (int k = 0; k < coof_pkg::DIV_STEP; k++) begin
            t = {r, q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t    = t - {1'b0, r_den};
                q[0] = 1'b1;
            end
            r = t[DEN_W-1:0];
        end
        n_quo = q;
        n_rem = r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== rtl/coof_dp.sv =====
// ----------------------------------------------------------------------------
// Clock offset outlier filter datapath
// Configuration registers, offset and deviation shift windows with running
// sums and nonzero counts, deviation and factor products, shared divider and
// the result register.
// ----------------------------------------------------------------------------
module coof_dp #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [coof_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [coof_pkg::FACT_W-1:0]    i_cfg_data,
    input  logic [coof_pkg::DATA_W-1:0]    i_sample,
    input  coof_pkg::t_dp_cmd              i_cmd,
    output coof_pkg::t_dp_sts              o_sts,
    output logic                           o_accepted,
    output logic [coof_pkg::DATA_W-1:0]    o_filtered_offset,
    output logic [coof_pkg::DEV_W-1:0]     o_mean_deviation
);

    localparam int DATA_W = coof_pkg::DATA_W;
    localparam int DEV_W  = coof_pkg::DEV_W;
    localparam int FACT_W = coof_pkg::FACT_W;
    localparam int PROD_W = coof_pkg::PROD_W;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW_DEPTH);
    localparam int DSUM_W = DEV_W + $clog2(WINDOW_DEPTH);
    localparam int DIV_W  = ((SUM_W + coof_pkg::DIV_STEP - 1) / coof_pkg::DIV_STEP)
                            * coof_pkg::DIV_STEP;
    localparam int CMP_W  = (CNT_W > FACT_W) ? CNT_W : FACT_W;

    logic [FACT_W-1:0] r_reject;
    logic [FACT_W-1:0] r_accept;
    logic [FACT_W-1:0] r_warmup;

    logic [DEV_W-1:0]  r_dev_win [WINDOW_DEPTH];
    logic [DATA_W-1:0] r_ofs_win [WINDOW_DEPTH];
    logic [DSUM_W-1:0] r_dev_sum;
    logic [SUM_W-1:0]  r_ofs_sum;
    logic [CNT_W-1:0]  r_dev_cnt;
    logic [CNT_W-1:0]  r_ofs_cnt;
    logic [DEV_W-1:0]  r_avg_dev;
    logic [DATA_W-1:0] r_avg_ofs;

    logic [DATA_W-1:0] r_sample;
    logic [DEV_W-1:0]  r_dev;
    logic [PROD_W-1:0] r_prod;
    logic              r_acc;
    logic              r_out_acc;
    logic [DATA_W-1:0] r_out_ofs;
    logic [DEV_W-1:0]  r_out_dev;

    logic [DATA_W:0]   w_diff;
    logic [DATA_W:0]   w_mag;
    logic [DEV_W-1:0]  w_dev;
    logic [SUM_W-1:0]  w_ofs_mag;
    logic [DIV_W-1:0]  w_dividend;
    logic [CNT_W-1:0]  w_divisor;
    logic [DIV_W-1:0]  w_quo;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quo_lo;

    assign w_diff = {r_sample[DATA_W-1], r_sample} - {r_avg_ofs[DATA_W-1], r_avg_ofs};
    assign w_mag  = w_diff[DATA_W] ? (~w_diff + 1'b1) : w_diff;
    assign w_dev  = (w_mag > {2'b00, coof_pkg::DEV_MAX}) ? coof_pkg::DEV_MAX
                                                         : w_mag[DEV_W-1:0];

    assign w_ofs_mag  = r_ofs_sum[SUM_W-1] ? (~r_ofs_sum + 1'b1) : r_ofs_sum;
    assign w_dividend = i_cmd.div_sel_ofs ? DIV_W'(w_ofs_mag) : DIV_W'(r_dev_sum);
    assign w_divisor  = i_cmd.div_sel_ofs ? r_ofs_cnt : r_dev_cnt;
    assign w_quo_lo   = w_quo[DATA_W-1:0];

    coof_div #(
        .DIV_W (DIV_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reject  <= coof_pkg::RST_REJECT_FACTOR;
            r_accept  <= coof_pkg::RST_ACCEPT_FACTOR;
            r_warmup  <= coof_pkg::RST_WARMUP_COUNT;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_dev_win[i] <= '0;
                r_ofs_win[i] <= '0;
            end
            r_dev_sum <= '0;
            r_ofs_sum <= '0;
            r_dev_cnt <= '0;
            r_ofs_cnt <= '0;
            r_avg_dev <= '0;
            r_avg_ofs <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    coof_pkg::REG_REJECT_FACTOR: r_reject <= i_cfg_data;
                    coof_pkg::REG_ACCEPT_FACTOR: r_accept <= i_cfg_data;
                    coof_pkg::REG_WARMUP_COUNT:  r_warmup <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.dev_push) begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                    r_dev_win[i] <= r_dev_win[i+1];
                end
                r_dev_win[WINDOW_DEPTH-1] <= r_dev;
                r_dev_sum <= r_dev_sum + DSUM_W'(r_dev) - DSUM_W'(r_dev_win[0]);
                r_dev_cnt <= r_dev_cnt + CNT_W'(r_dev != '0)
                             - CNT_W'(r_dev_win[0] != '0);
            end
            if (i_cmd.ofs_push) begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                    r_ofs_win[i] <= r_ofs_win[i+1];
                end
                r_ofs_win[WINDOW_DEPTH-1] <= r_sample;
                r_ofs_sum <= r_ofs_sum
                             + {{(SUM_W-DATA_W){r_sample[DATA_W-1]}}, r_sample}
                             - {{(SUM_W-DATA_W){r_ofs_win[0][DATA_W-1]}}, r_ofs_win[0]};
                r_ofs_cnt <= r_ofs_cnt + CNT_W'(r_sample != '0)
                             - CNT_W'(r_ofs_win[0] != '0);
            end
            if (i_cmd.wr_avg_dev) begin
                r_avg_dev <= (r_dev_cnt == '0) ? '0 : w_quo[DEV_W-1:0];
            end
            if (i_cmd.wr_avg_ofs) begin
                if (r_ofs_cnt == '0) begin
                    r_avg_ofs <= '0;
                end else if (r_ofs_sum[SUM_W-1]) begin
                    r_avg_ofs <= ~w_quo_lo + 1'b1;
                end else begin
                    r_avg_ofs <= w_quo_lo;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample;
            r_acc    <= 1'b0;
        end
        if (i_cmd.ofs_push) begin
            r_acc <= 1'b1;
        end
        if (i_cmd.calc_dev) begin
            r_dev <= w_dev;
        end
        if (i_cmd.mul_rej) begin
            r_prod <= PROD_W'(r_avg_dev) * PROD_W'(r_reject);
        end else if (i_cmd.mul_acc) begin
            r_prod <= PROD_W'(r_avg_dev) * PROD_W'(r_accept);
        end
        if (i_cmd.load_out) begin
            r_out_acc <= r_acc;
            r_out_ofs <= r_avg_ofs;
            r_out_dev <= r_avg_dev;
        end
    end

    assign o_sts.ofs_zero     = (r_avg_ofs == '0);
    assign o_sts.early_reject = (r_avg_dev != '0)
                                && (CMP_W'(r_dev_cnt) > CMP_W'(r_warmup))
                                && (PROD_W'(r_dev) > r_prod);
    assign o_sts.accept_ok    = (r_dev_cnt != CNT_W'(WINDOW_DEPTH))
                                || (PROD_W'(r_dev) < r_prod);
    assign o_sts.div_done     = w_div_done;

    assign o_accepted        = r_out_acc;
    assign o_filtered_offset = r_out_ofs;
    assign o_mean_deviation  = r_out_dev;

endmodule

// ===== rtl/coof_ctrl.sv =====
// ----------------------------------------------------------------------------
// Clock offset outlier filter controller
// Sequences one sample through deviation, early rejection, deviation average,
// acceptance test and offset average, and owns the result valid flag.
// ----------------------------------------------------------------------------
module coof_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    input  coof_pkg::t_dp_sts i_sts,
    output coof_pkg::t_dp_cmd o_cmd
);

    coof_pkg::t_state r_state;
    coof_pkg::t_state n_state;
    logic             r_out_vld;
    logic             n_out_vld;
    logic             w_out_free;

    assign w_out_free = !r_out_vld || i_m_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            coof_pkg::S_IDLE: begin
                if (i_s_valid) begin
                    n_state = i_sts.ofs_zero ? coof_pkg::S_OFS_PUSH : coof_pkg::S_DEV;
                end
            end
            coof_pkg::S_DEV:        n_state = coof_pkg::S_CHECK;
            coof_pkg::S_CHECK: begin
                n_state = i_sts.early_reject ? coof_pkg::S_OUT : coof_pkg::S_DEV_PUSH;
            end
            coof_pkg::S_DEV_PUSH:   n_state = coof_pkg::S_DEV_DIV_GO;
            coof_pkg::S_DEV_DIV_GO: n_state = coof_pkg::S_DEV_DIV_WAIT;
            coof_pkg::S_DEV_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = coof_pkg::S_ACC_MUL;
                end
            end
            coof_pkg::S_ACC_MUL:    n_state = coof_pkg::S_ACC_CHK;
            coof_pkg::S_ACC_CHK: begin
                n_state = i_sts.accept_ok ? coof_pkg::S_OFS_PUSH : coof_pkg::S_OUT;
            end
            coof_pkg::S_OFS_PUSH:   n_state = coof_pkg::S_OFS_DIV_GO;
            coof_pkg::S_OFS_DIV_GO: n_state = coof_pkg::S_OFS_DIV_WAIT;
            coof_pkg::S_OFS_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = coof_pkg::S_OUT;
                end
            end
            coof_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = coof_pkg::S_IDLE;
                end
            end
            default:                n_state = coof_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            coof_pkg::S_IDLE: begin
                o_s_ready         = 1'b1;
                o_cmd.load_sample = i_s_valid;
            end
            coof_pkg::S_DEV: begin
                o_cmd.calc_dev = 1'b1;
                o_cmd.mul_rej  = 1'b1;
            end
            coof_pkg::S_DEV_PUSH:     o_cmd.dev_push = 1'b1;
            coof_pkg::S_DEV_DIV_GO:   o_cmd.div_start = 1'b1;
            coof_pkg::S_DEV_DIV_WAIT: o_cmd.wr_avg_dev = i_sts.div_done;
            coof_pkg::S_ACC_MUL:      o_cmd.mul_acc = 1'b1;
            coof_pkg::S_OFS_PUSH:     o_cmd.ofs_push = 1'b1;
            coof_pkg::S_OFS_DIV_GO: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_ofs = 1'b1;
            end
            coof_pkg::S_OFS_DIV_WAIT: begin
                o_cmd.div_sel_ofs = 1'b1;
                o_cmd.wr_avg_ofs  = i_sts.div_done;
            end
            coof_pkg::S_OUT:          o_cmd.load_out = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        priority if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_m_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= coof_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_m_valid = r_out_vld;

endmodule

// ===== rtl/clock_offset_outlier_filter_core.sv =====
// ----------------------------------------------------------------------------
// Clock offset outlier filter core
// Moving average of clock offsets with rejection of samples whose deviation
// from the current average is large against the average deviation.
//
//   Channel  Direction  Handshake               Payload
//   s        in         i_s_tvalid/o_s_tready   offset_sample
//   m        out        o_m_tvalid/i_m_tready   filtered_offset, mean_deviation,
//                                               accepted (tuser)
//   cfg      in         i_cfg_valid/o_cfg_ready register index, 4-bit data
//
// A sample dropped early skips both divisions; one that comes while no offset average
// exists runs only the offset division; any other runs the deviation division and,
// if it passes the acceptance test, the offset division, both on the shared
// four-bit-per-cycle divider, whose dividend holds the SUM_W = 64 + clog2(WINDOW_DEPTH) bit sum.
// Reset is synchronous and active low; it clears both windows and averages.
// A waiting result stalls only the result step of the next sample.
// ----------------------------------------------------------------------------
module clock_offset_outlier_filter_core #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // offset_sample[63:0]
    input  logic [coof_pkg::DATA_W-1:0]     i_s_tdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // filtered_offset[63:0], mean_deviation[126:64], zero pad[127]
    output logic [coof_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // accepted[0]
    output logic                            o_m_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [coof_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [coof_pkg::FACT_W-1:0]     i_cfg_data
);

    coof_pkg::t_dp_cmd            w_cmd;
    coof_pkg::t_dp_sts            w_sts;
    logic                         w_accepted;
    logic [coof_pkg::DATA_W-1:0]  w_filtered_offset;
    logic [coof_pkg::DEV_W-1:0]   w_mean_deviation;

    coof_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    coof_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_s_tdata),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_accepted        (w_accepted),
        .o_filtered_offset (w_filtered_offset),
        .o_mean_deviation  (w_mean_deviation)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {1'b0, w_mean_deviation, w_filtered_offset};
    assign o_m_tuser   = w_accepted;

endmodule

// ===== rtl/coof_chk.sv =====
// ----------------------------------------------------------------------------
// Clock offset outlier filter checker
// Port-level checks on the filter core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
`include "clock_offset_outlier_filter_core_assert.svh"

module coof_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [coof_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                            o_m_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready
);

    logic w_in_xfer;

    assign w_in_xfer = i_s_tvalid && o_s_tready;

    `COOF_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)), "result changed before its transfer")
    `COOF_ASSERT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
    `COOF_ASSERT(a_busy_after_in, i_clk, i_rst_n, w_in_xfer |=> !o_s_tready, "sample taken while one is in work")
    `COOF_ASSERT(a_no_instant_out, i_clk, i_rst_n, w_in_xfer |=> !$rose(o_m_tvalid), "result shown in the cycle after a sample transfer")

endmodule

bind clock_offset_outlier_filter_core coof_chk u_coof_chk (.*);

// ===== verif/tb_clock_offset_outlier_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset outlier filter core testbench
// Sends clock offset samples through the stream input and checks every
// filter result against a cycle-free copy of the windowed averages and the
// outlier rules. A short table of hand-picked samples comes first. It is
// followed by phases of random samples, each under its own register setting.
// Both stream sides pause at random.
// ----------------------------------------------------------------------------
module tb_clock_offset_outlier_filter_core;

    localparam int          WIN_DEPTH       = 10;
    localparam int          PHASES          = 27;
    localparam int          SAMPLES_PER_PHASE = 50;
    localparam int          DRAIN_CYCLES    = 60;
    localparam logic [1:0]  REG_UNMAPPED    = 2'd3;
    localparam logic [63:0] OFFSET_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] OFFSET_MIN      = 64'h8000_0000_0000_0000;

    typedef logic [63:0] t_window [WIN_DEPTH];

    typedef struct packed {
        logic        accepted;
        logic [63:0] filtered_offset;
        logic [62:0] mean_deviation;
    } t_filter_result;

    typedef struct packed {
        logic [63:0]    sample;
        logic           pinned;
        t_filter_result want;
    } t_stimulus_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic [coof_pkg::DATA_W-1:0]     i_s_tdata;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [coof_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            o_m_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [coof_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [coof_pkg::FACT_W-1:0]     i_cfg_data;

    t_window        kept_offsets;
    t_window        kept_deviations;
    logic [63:0]    offset_average;
    logic [63:0]    deviation_average;
    logic [3:0]     reject_gain;
    logic [3:0]     accept_gain;
    logic [3:0]     warmup_needed;
    t_filter_result expected_results [$];
    int unsigned    mismatch_count = 0;
    int unsigned    idle_odds = 4;

    clock_offset_outlier_filter_core #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned occupied(input t_window w);
        int unsigned n;
        n = 0;
        foreach (w[i]) begin
            if (w[i] != '0) n++;
        end
        return n;
    endfunction

    // Signed mean over the nonzero entries, truncated toward zero.
    function automatic logic [63:0] window_mean(input t_window w);
        logic [69:0] total;
        logic [69:0] mag;
        int unsigned n;
        total = '0;
        foreach (w[i]) total += {{6{w[i][63]}}, w[i]};
        n = occupied(w);
        if (n == 0) return '0;
        mag = total[69] ? -total : total;
        mag = mag / 70'(n);
        return total[69] ? -mag[63:0] : mag[63:0];
    endfunction

    function automatic void shift_in(inout t_window w, input logic [63:0] v);
        for (int i = 0; i < WIN_DEPTH - 1; i++) w[i] = w[i + 1];
        w[WIN_DEPTH - 1] = v;
    endfunction

    function automatic logic [67:0] scaled(input logic [63:0] a, input logic [3:0] f);
        return 68'(a) * 68'(f);
    endfunction

    // Exact distance between two signed offsets, clipped to the 63-bit range.
    function automatic logic [63:0] distance(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] diff;
        diff = {a[63], a} - {b[63], b};
        if (diff[64]) diff = -diff;
        return (diff > 65'(coof_pkg::DEV_MAX)) ? 64'(coof_pkg::DEV_MAX) : diff[63:0];
    endfunction

    function automatic t_filter_result apply_sample(input logic [63:0] sample);
        t_filter_result r;
        logic [63:0]    dev;
        logic           ok;
        ok = 1'b1;
        if (offset_average != '0) begin
            dev = distance(sample, offset_average);
            if (deviation_average != '0 && occupied(kept_deviations) > warmup_needed &&
                {4'b0, dev} > scaled(deviation_average, reject_gain)) begin
                ok = 1'b0;
            end else begin
                shift_in(kept_deviations, dev);
                deviation_average = window_mean(kept_deviations);
                if (occupied(kept_deviations) == WIN_DEPTH)
                    ok = {4'b0, dev} < scaled(deviation_average, accept_gain);
            end
        end
        if (ok) begin
            shift_in(kept_offsets, sample);
            offset_average = window_mean(kept_offsets);
        end
        r.accepted        = ok;
        r.filtered_offset = offset_average;
        r.mean_deviation  = deviation_average[62:0];
        return r;
    endfunction

    function automatic logic [63:0] draw_sample(input bit wild, input logic [63:0] center,
                                                input int unsigned bits);
        logic [63:0] noise;
        int unsigned pick;
        noise = {$urandom, $urandom};
        if (wild) return noise;
        pick  = $urandom_range(0, 99);
        noise = (noise & ((64'd1 << bits) - 64'd1)) - (64'd1 << (bits - 1));
        if (pick < 3) return '0;
        if (pick < 5) begin
            case ($urandom_range(0, 2))
                0:       return OFFSET_MAX;
                1:       return OFFSET_MIN;
                default: return {$urandom, $urandom};
            endcase
        end
        if (pick < 13) return center + (noise << $urandom_range(4, 20));
        return center + noise;
    endfunction

    task automatic send_sample(input logic [63:0] value, input bit pinned,
                               input t_filter_result want);
        t_filter_result predicted;
        int unsigned    gap;
        gap = (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) ? $urandom_range(1, 9) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = apply_sample(value);
        expected_results.push_back(pinned ? want : predicted);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [3:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            coof_pkg::REG_REJECT_FACTOR: reject_gain   = value;
            coof_pkg::REG_ACCEPT_FACTOR: accept_gain   = value;
            coof_pkg::REG_WARMUP_COUNT:  warmup_needed = value;
            default: ;
        endcase
    endtask

    task automatic settle();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_filter_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no sample outstanding");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_m_tuser !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, o_m_tuser);
                    mismatch_count++;
                end
                if (o_m_tdata[63:0] !== want.filtered_offset) begin
                    $error("filtered_offset: expected %0d, got %0d",
                           $signed(want.filtered_offset), $signed(o_m_tdata[63:0]));
                    mismatch_count++;
                end
                if (o_m_tdata[126:64] !== want.mean_deviation) begin
                    $error("mean_deviation: expected %0d, got %0d",
                           want.mean_deviation, o_m_tdata[126:64]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : sink_pacing
        int unsigned stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                stall_left = $urandom_range(1, 9);
            if (stall_left != 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_stimulus_row rows [$];
        logic [63:0]   center;
        int unsigned   jitter_bits;
        bit            wild;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        foreach (kept_offsets[i]) begin
            kept_offsets[i]    = '0;
            kept_deviations[i] = '0;
        end
        offset_average    = '0;
        deviation_average = '0;
        reject_gain       = coof_pkg::RST_REJECT_FACTOR;
        accept_gain       = coof_pkg::RST_ACCEPT_FACTOR;
        warmup_needed     = coof_pkg::RST_WARMUP_COUNT;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The first samples run on the reset register values. A pair that
        // cancels brings the offset average back to zero, so the sample after
        // it is taken without a deviation check.
        rows = '{
            '{64'd5,         1'b1, '{1'b1, 64'd5,   63'd0}},
            '{-64'sd5,       1'b1, '{1'b1, 64'd0,   63'd10}},
            '{64'd1000,      1'b1, '{1'b1, 64'd333, 63'd10}},
            '{64'd0,         1'b0, '0},
            '{64'd1010,      1'b0, '0},
            '{64'd990,       1'b0, '0},
            '{64'd1005,      1'b0, '0},
            '{64'd995,       1'b0, '0},
            '{64'd1002,      1'b0, '0},
            '{64'd998,       1'b0, '0},
            '{64'd1001,      1'b0, '0},
            '{64'd1_000_000_000, 1'b0, '0},
            '{64'd999,       1'b0, '0},
            '{64'd1003,      1'b0, '0},
            '{64'd997,       1'b0, '0},
            '{64'd1000,      1'b0, '0},
            '{64'd1400,      1'b0, '0},
            '{-64'sd900,     1'b0, '0},
            '{OFFSET_MAX,    1'b0, '0},
            '{OFFSET_MIN,    1'b0, '0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{64'd1,         1'b0, '0}
        };
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].pinned, rows[i].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            settle();
            case (phase % 4)
                0: begin
                    write_register(coof_pkg::REG_REJECT_FACTOR, 4'd1);
                    write_register(coof_pkg::REG_ACCEPT_FACTOR, 4'd1);
                    write_register(coof_pkg::REG_WARMUP_COUNT,  4'd0);
                end
                1: begin
                    write_register(coof_pkg::REG_REJECT_FACTOR, 4'd15);
                    write_register(coof_pkg::REG_ACCEPT_FACTOR, 4'd15);
                    write_register(coof_pkg::REG_WARMUP_COUNT,  4'd10);
                end
                2: begin
                    write_register(coof_pkg::REG_REJECT_FACTOR, 4'd0);
                    write_register(coof_pkg::REG_ACCEPT_FACTOR, 4'd0);
                    write_register(coof_pkg::REG_WARMUP_COUNT,  4'd15);
                end
                default: begin
                    write_register(coof_pkg::REG_REJECT_FACTOR, 4'($urandom_range(0, 15)));
                    write_register(coof_pkg::REG_ACCEPT_FACTOR, 4'($urandom_range(0, 15)));
                    write_register(coof_pkg::REG_WARMUP_COUNT,  4'($urandom_range(0, 15)));
                end
            endcase
            write_register(REG_UNMAPPED, 4'($urandom_range(0, 15)));
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;

            if (phase >= PHASES - 3 || phase % 5 == 2)
                idle_odds = 0;
            else
                idle_odds = $urandom_range(2, 10);

            wild        = ($urandom_range(0, 5) == 0);
            jitter_bits = $urandom_range(1, 40);
            if (phase % 3 == 0 || offset_average == '0)
                center = {$urandom, $urandom} >>> $urandom_range(1, 63);
            else
                center = offset_average;

            for (int k = 0; k < SAMPLES_PER_PHASE; k++)
                send_sample(draw_sample(wild, center, jitter_bits), 1'b0, '0);
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        settle();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/coof_pkg.sv
rtl/coof_div.sv
rtl/coof_dp.sv
rtl/coof_ctrl.sv
rtl/clock_offset_outlier_filter_core.sv
rtl/coof_chk.sv
verif/tb_clock_offset_outlier_filter_core.sv
